[rtl/mpf_pkg.sv]
// ----------------------------------------------------------------------------
// mpf_pkg
// Shared constants for the FIOS Montgomery product unit: default sizes,
// configuration register map and register reset values.
// ----------------------------------------------------------------------------
package mpf_pkg;

    // default operand shape
    localparam int MAX_DIGITS_DEF = 64;
    localparam int DIGIT_BITS_DEF = 32;

    // configuration port
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;
    localparam int NUM_DIGITS_W = 7;

    // register select (address bit 2)
    localparam logic [0:0] REG_NUM_DIGITS  = 1'b0;
    localparam logic [0:0] REG_N_PRIME_LOW = 1'b1;

    // register reset values
    localparam logic [NUM_DIGITS_W-1:0] NUM_DIGITS_RST = 7'd64;

endpackage

[rtl/montgomery_product_fios_unit.sv]
// Loading: one operand word per cycle while idle; the last word starts the run.
// Compute: runs on one shared DIGIT_BITS x DIGIT_BITS multiplier
// (two multiplies per digit pair), then a settle state and a word compare from the top down.
// Output: s result words, one per cycle when result_ready stays high.
// Operands: no new words are taken during a run, only once the unit is idle again.
// Reset: asynchronous; clears control, counters and config; stores are not cleared.
// ----------------------------------------------------------------------------
// montgomery_product_fios_unit
// Word-serial Montgomery product a*b*R^-1 mod n (FIOS) with a single shared
// multiplier under a small sequencer, a final conditional subtraction of n
// and an APB-style configuration port.
// ----------------------------------------------------------------------------
module montgomery_product_fios_unit
    import mpf_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF,
    parameter int DIGIT_BITS = DIGIT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // input words
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DIGIT_BITS-1:0] a_digit,
    input  logic [DIGIT_BITS-1:0] b_digit,
    input  logic [DIGIT_BITS-1:0] mod_digit,

    // result words
    output logic                  result_valid,
    input  logic                  result_ready,
    output logic [DIGIT_BITS-1:0] result_digit,
    output logic                  result_last,

    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int DW    = DIGIT_BITS;
    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_X,
        ST_Y,
        ST_M0,
        ST_M1,
        ST_FIN1,
        ST_FIN2,
        ST_SETTLE,
        ST_CMP,
        ST_OUT
    } state_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [NUM_DIGITS_W-1:0] num_digits_reg;
    logic [DW-1:0]           n_prime_reg;
    logic                    cfg_we;
    logic [0:0]              cfg_sel;

    assign pready  = 1'b1;
    assign cfg_sel = paddr[2:2];
    assign cfg_we  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_digits_reg <= NUM_DIGITS_RST;
            n_prime_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_sel)
                REG_NUM_DIGITS:  num_digits_reg <= pwdata[NUM_DIGITS_W-1:0];
                REG_N_PRIME_LOW: n_prime_reg    <= pwdata[DW-1:0];
            endcase
        end
    end

    // register read back
    always_comb
    begin
        unique case (cfg_sel)
            REG_NUM_DIGITS:  prdata = APB_DATA_W'(num_digits_reg);
            REG_N_PRIME_LOW: prdata = APB_DATA_W'(n_prime_reg);
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer and datapath registers
    // ------------------------------------------------------------------
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] load_count_reg, load_count_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] last_idx_reg, last_idx_next;
    logic             sub_reg, sub_next;
    logic             out_valid_reg, out_valid_next;
    logic [DW-1:0]    out_digit_reg, out_digit_next;
    logic             out_last_reg, out_last_next;

    logic [2*DW-1:0]  prod_reg, prod_next;
    logic [DW-1:0]    lo_reg, lo_next;
    logic [DW-1:0]    c0_reg, c0_next;
    logic [DW-1:0]    c1_reg, c1_next;
    logic [DW-1:0]    m_reg, m_next;
    logic [1:0]       t_top_reg, t_top_next;
    logic             borrow_reg, borrow_next;

    // memory read data
    logic [DW-1:0]    a_rd, b_rd, n_rd, t_rd;

    // accumulator write port
    logic             t_we;
    logic [IDX_W-1:0] t_waddr;
    logic [DW-1:0]    t_wdata;

    // load side
    logic             load_we;
    logic [IDX_W-1:0] load_idx;
    logic [CNT_W-1:0] load_cnt_inc;
    logic [CNT_W-1:0] s_use;

    // arithmetic
    logic [DW-1:0]    mul_a, mul_b;
    logic [DW-1:0]    t_val;
    logic [2*DW-1:0]  add1, add2;
    logic [DW:0]      fin_x, fin_y;
    logic [DW:0]      sub_diff;

    assign in_ready     = (state_reg == ST_IDLE);
    assign load_we      = in_valid & in_ready;
    assign result_valid = out_valid_reg;
    assign result_digit = out_digit_reg;
    assign result_last  = out_last_reg;

    // digit count in use: zero counts as one, clamp at the store depth
    always_comb
    begin
        if (num_digits_reg == '0)
            s_use = CNT_W'(1);
        else if (int'(num_digits_reg) > MAX_DIGITS)
            s_use = CNT_W'(MAX_DIGITS);
        else
            s_use = CNT_W'(num_digits_reg);
    end

    // store slot for the next word, stuck at the top once full
    always_comb
    begin
        if (int'(load_count_reg) >= MAX_DIGITS)
            load_idx = IDX_W'(MAX_DIGITS - 1);
        else
            load_idx = load_count_reg[IDX_W-1:0];
        load_cnt_inc = CNT_W'(load_idx) + CNT_W'(1);
    end

    // first pass sees an all-zero accumulator
    assign t_val = (i_reg == '0) ? '0 : t_rd;

    // shared multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            ST_Y:
            begin
                mul_a = m_reg;
                mul_b = n_rd;
            end
            ST_M0:
            begin
                mul_a = lo_reg;
                mul_b = n_prime_reg;
            end
            ST_M1:
            begin
                mul_a = prod_reg[DW-1:0];
                mul_b = n_rd;
            end
            default:
            begin
                mul_a = a_rd;
                mul_b = b_rd;
            end
        endcase
    end

    // product chain, reduction chain, top word and final subtract
    assign add1     = (2*DW)'(t_val) + prod_reg + (2*DW)'(c0_reg);
    assign add2     = (2*DW)'(lo_reg) + prod_reg + (2*DW)'(c1_reg);
    assign fin_x    = (DW+1)'(c0_reg) + (DW+1)'(c1_reg);
    assign fin_y    = (DW+1)'(t_top_reg) + (DW+1)'(fin_x[DW-1:0]);
    assign sub_diff = (DW+1)'(t_rd) - (DW+1)'(n_rd) - (DW+1)'(borrow_reg);

    // next-state logic
    always_comb
    begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        last_idx_next   = last_idx_reg;
        sub_next        = sub_reg;
        out_valid_next  = out_valid_reg & ~result_ready;
        out_digit_next  = out_digit_reg;
        out_last_next   = out_last_reg;

        prod_next   = mul_a * mul_b;
        lo_next     = lo_reg;
        c0_next     = c0_reg;
        c1_next     = c1_reg;
        m_next      = m_reg;
        t_top_next  = t_top_reg;
        borrow_next = borrow_reg;

        t_we    = 1'b0;
        t_waddr = j_reg;
        t_wdata = add2[DW-1:0];

        unique case (state_reg)
            // take words; the last one starts the run
            ST_IDLE:
            begin
                if (load_we)
                begin
                    if (load_cnt_inc >= s_use)
                    begin
                        load_count_next = '0;
                        last_idx_next   = IDX_W'(s_use - CNT_W'(1));
                        i_next          = '0;
                        j_next          = '0;
                        state_next      = ST_START;
                    end
                    else
                    begin
                        load_count_next = load_cnt_inc;
                    end
                end
            end

            // let the last stored word reach the read ports
            ST_START:
            begin
                t_top_next = '0;
                state_next = ST_X;
            end

            // a[j]*b[i]; closes the reduction step of word j-1
            ST_X:
            begin
                if (j_reg == '0)
                begin
                    c0_next = '0;
                    c1_next = '0;
                end
                else
                begin
                    c1_next = add2[2*DW-1:DW];
                    if (j_reg > IDX_W'(1))
                    begin
                        t_we    = 1'b1;
                        t_waddr = j_reg - IDX_W'(2);
                    end
                end
                state_next = ST_Y;
            end

            // accumulate t[j] + a[j]*b[i] + c0; m*n[j] for j above zero
            ST_Y:
            begin
                lo_next = add1[DW-1:0];
                c0_next = add1[2*DW-1:DW];
                if (j_reg == '0)
                begin
                    state_next = ST_M0;
                end
                else if (j_reg == last_idx_reg)
                begin
                    state_next = ST_FIN1;
                end
                else
                begin
                    j_next     = j_reg + IDX_W'(1);
                    state_next = ST_X;
                end
            end

            // m = lo*n' (low word)
            ST_M0:
            begin
                state_next = ST_M1;
            end

            // m*n[0]
            ST_M1:
            begin
                m_next = prod_reg[DW-1:0];
                if (last_idx_reg == '0)
                begin
                    state_next = ST_FIN1;
                end
                else
                begin
                    j_next     = IDX_W'(1);
                    state_next = ST_X;
                end
            end

            // close the reduction step of the top word
            ST_FIN1:
            begin
                c1_next = add2[2*DW-1:DW];
                if (j_reg != '0)
                begin
                    t_we    = 1'b1;
                    t_waddr = j_reg - IDX_W'(1);
                end
                state_next = ST_FIN2;
            end

            // fold both carries into the top words
            ST_FIN2:
            begin
                t_we       = 1'b1;
                t_waddr    = last_idx_reg;
                t_wdata    = fin_y[DW-1:0];
                t_top_next = 2'(fin_x[DW]) + 2'(fin_y[DW]);
                if (i_reg == last_idx_reg)
                begin
                    j_next     = last_idx_reg;
                    state_next = ST_SETTLE;
                end
                else
                begin
                    i_next     = i_reg + IDX_W'(1);
                    j_next     = '0;
                    state_next = ST_X;
                end
            end

            // wait for the last accumulator write to be readable
            ST_SETTLE:
            begin
                state_next = ST_CMP;
            end

            // compare accumulator against n, most significant word first
            ST_CMP:
            begin
                borrow_next = 1'b0;
                priority if (t_top_reg != '0)
                begin
                    sub_next   = 1'b1;
                    j_next     = '0;
                    state_next = ST_OUT;
                end
                else if (t_rd != n_rd)
                begin
                    sub_next   = (t_rd > n_rd);
                    j_next     = '0;
                    state_next = ST_OUT;
                end
                else if (j_reg == '0)
                begin
                    sub_next   = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    j_next = j_reg - IDX_W'(1);
                end
            end

            // emit result words, subtracting n with ripple borrow if needed
            ST_OUT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = (j_reg == last_idx_reg);
                    if (sub_reg)
                    begin
                        out_digit_next = sub_diff[DW-1:0];
                        borrow_next    = sub_diff[DW];
                    end
                    else
                    begin
                        out_digit_next = t_rd;
                    end
                    if (j_reg == last_idx_reg)
                        state_next = ST_IDLE;
                    else
                        j_next = j_reg + IDX_W'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            load_count_reg <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            last_idx_reg   <= '0;
            sub_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_digit_reg  <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            last_idx_reg   <= last_idx_next;
            sub_reg        <= sub_next;
            out_valid_reg  <= out_valid_next;
            out_digit_reg  <= out_digit_next;
            out_last_reg   <= out_last_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        lo_reg     <= lo_next;
        c0_reg     <= c0_next;
        c1_reg     <= c1_next;
        m_reg      <= m_next;
        t_top_reg  <= t_top_next;
        borrow_reg <= borrow_next;
    end

    // ------------------------------------------------------------------
    // operand stores and accumulator memory
    // ------------------------------------------------------------------
    logic [DW-1:0] a_mem [MAX_DIGITS];
    logic [DW-1:0] b_mem [MAX_DIGITS];
    logic [DW-1:0] n_mem [MAX_DIGITS];
    logic [DW-1:0] t_mem [MAX_DIGITS];

    // operand stores: written while loading, read at the next index
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            a_mem[load_idx] <= a_digit;
            b_mem[load_idx] <= b_digit;
            n_mem[load_idx] <= mod_digit;
        end
        a_rd <= a_mem[j_next];
        n_rd <= n_mem[j_next];
        b_rd <= b_mem[i_next];
    end

    // accumulator words below the top
    always_ff @(posedge clk)
    begin
        if (t_we)
            t_mem[t_waddr] <= t_wdata;
        t_rd <= t_mem[j_next];
    end

endmodule
